// ===== rtl/core/rgb555_lcd_color_correct_macros.svh =====
// assertion macros for the lcd colour correction block
// used by rlcc_out_gamma and rgb555_lcd_color_correct; needs clk and rst_n in scope
`ifndef RGB555_LCD_COLOR_CORRECT_MACROS_SVH
`define RGB555_LCD_COLOR_CORRECT_MACROS_SVH

// same-cycle implication, checked out of reset
`define RLCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RLCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rlcc_pkg.sv =====
// shared types, constants and constant tables for the lcd colour correction block
// no dependencies; the interfaces and modules refer to it by scoped names
package rlcc_pkg;

    // widths
    localparam int GAMMA_INDEX_BITS = 10;
    localparam int SUM_BITS         = 17;
    localparam int GAMMA_SHIFT      = SUM_BITS - GAMMA_INDEX_BITS;
    localparam int GAMMA_DEPTH      = 1 << GAMMA_INDEX_BITS;
    localparam int CHAN_BITS        = 5;
    localparam int PIXEL_BITS       = 15;
    localparam int LIN_BITS         = 16;
    localparam int OUT_BITS         = 16;
    localparam int MIX_BITS         = 25;
    localparam int LIN_ENTRIES      = 32;

    // linearisation curve constants
    localparam longint LIN_FULL = 65535;
    localparam longint LIN_DEN  = 923521;

    // output curve constants
    localparam int OUT_SCALE = 59683;
    localparam int BIG_BITS  = 280;

    // divide by 255 through a reciprocal: exact for sums below 2^25
    localparam int DIV_SHIFT = 33;
    localparam int DIV_BITS  = 26;
    localparam logic [DIV_BITS-1:0] DIV_MUL = 26'd33686019;
    localparam int PROD_BITS = MIX_BITS + DIV_BITS;

    // mixing weights
    localparam logic [7:0] W_RR = 8'd255;
    localparam logic [7:0] W_RG = 8'd50;
    localparam logic [7:0] W_RB = 8'd0;
    localparam logic [7:0] W_GR = 8'd10;
    localparam logic [7:0] W_GG = 8'd230;
    localparam logic [7:0] W_GB = 8'd30;
    localparam logic [7:0] W_BR = 8'd50;
    localparam logic [7:0] W_BG = 8'd10;
    localparam logic [7:0] W_BB = 8'd220;

    typedef logic [MIX_BITS-1:0] mix_t;
    typedef logic [PROD_BITS-1:0] prod_t;
    typedef logic [BIG_BITS-1:0] big_t;

    typedef logic [LIN_BITS-1:0] lin_table_t [LIN_ENTRIES];
    typedef logic [OUT_BITS-1:0] gamma_table_t [GAMMA_DEPTH];

    // stage words
    typedef struct packed {
        logic                    mode;
        logic [PIXEL_BITS-1:0]   pixel;
        logic [LIN_BITS-1:0]     lr;
        logic [LIN_BITS-1:0]     lg;
        logic [LIN_BITS-1:0]     lb;
    } lin_word_t;

    typedef struct packed {
        logic                    mode;
        logic [PIXEL_BITS-1:0]   pixel;
        logic [MIX_BITS-1:0]     sr;
        logic [MIX_BITS-1:0]     sg;
        logic [MIX_BITS-1:0]     sb;
    } mix_word_t;

    typedef struct packed {
        logic                    mode;
        logic [PIXEL_BITS-1:0]   pixel;
        logic [SUM_BITS-1:0]     sr;
        logic [SUM_BITS-1:0]     sg;
        logic [SUM_BITS-1:0]     sb;
    } sum_word_t;

    typedef struct packed {
        logic                    mode;
        logic [OUT_BITS-1:0]     red;
        logic [OUT_BITS-1:0]     green;
        logic [OUT_BITS-1:0]     blue;
    } rgb_word_t;

    // gamma 4 table: round(65535 * n^4 / 31^4)
    function automatic lin_table_t build_lin_table();
        lin_table_t tbl;
        longint     p;
        for (int n = 0; n < LIN_ENTRIES; n++) begin
            p = longint'(n) * n * n * n;
            tbl[n] = LIN_BITS'((2 * LIN_FULL * p + LIN_DEN) / (2 * LIN_DEN));
        end
        return tbl;
    endfunction

    // gamma 1/2.2 table: largest y with y^11 * 65535^5 <= v^5 * 59683^11
    function automatic gamma_table_t build_gamma_table();
        gamma_table_t          tbl;
        big_t                  scale_pow;
        big_t                  full_pow;
        big_t                  target;
        big_t                  trial;
        logic [SUM_BITS-1:0]   v;
        int                    lo;
        int                    hi;
        int                    mid;
        scale_pow = big_t'(1);
        for (int k = 0; k < 11; k++) begin
            scale_pow = scale_pow * big_t'(OUT_SCALE);
        end
        full_pow = big_t'(1);
        for (int k = 0; k < 5; k++) begin
            full_pow = full_pow * big_t'(LIN_FULL);
        end
        for (int idx = 0; idx < GAMMA_DEPTH; idx++) begin
            v = SUM_BITS'(idx << GAMMA_SHIFT);
            target = scale_pow;
            for (int k = 0; k < 5; k++) begin
                target = target * big_t'(v);
            end
            lo = 0;
            hi = 65535;
            for (int it = 0; it < 17; it++) begin
                if (lo < hi) begin
                    mid = (lo + hi + 1) >> 1;
                    trial = full_pow;
                    for (int k = 0; k < 11; k++) begin
                        trial = trial * big_t'(mid);
                    end
                    if (trial <= target) begin
                        lo = mid;
                    end else begin
                        hi = mid - 1;
                    end
                end
            end
            tbl[idx] = OUT_BITS'(lo);
        end
        return tbl;
    endfunction

    localparam lin_table_t   LIN_TABLE   = build_lin_table();
    localparam gamma_table_t GAMMA_TABLE = build_gamma_table();

    // plain mode: widen 5 bits to 16 by replication
    function automatic logic [OUT_BITS-1:0] widen5(input logic [CHAN_BITS-1:0] c);
        return {c, c, c, c[CHAN_BITS-1]};
    endfunction

endpackage

// ===== rtl/core/rlcc_pixel_if.sv =====
// input channel of the lcd colour correction block: one 15-bit pixel per word
// depends on rlcc_pkg
interface rlcc_pixel_if;
    logic                              valid;
    logic                              ready;
    logic [rlcc_pkg::PIXEL_BITS-1:0]   pixel_bgr555;

    modport source (output valid, output pixel_bgr555, input ready);
    modport sink (input valid, input pixel_bgr555, output ready);
endinterface

// ===== rtl/core/rlcc_rgb_if.sv =====
// output channel of the lcd colour correction block: 16-bit red, green, blue per word
// depends on rlcc_pkg
interface rlcc_rgb_if;
    logic                            valid;
    logic                            ready;
    logic [rlcc_pkg::OUT_BITS-1:0]   red_out;
    logic [rlcc_pkg::OUT_BITS-1:0]   green_out;
    logic [rlcc_pkg::OUT_BITS-1:0]   blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

// ===== rtl/core/rlcc_linearise.sv =====
// pipeline stage 1: split the pixel and linearise each channel with gamma 4
// depends on rlcc_pkg (LIN_TABLE, lin_word_t)
module rlcc_linearise (
    input  logic                              clk,
    input  logic                              adv,
    input  logic                              mode,
    input  logic [rlcc_pkg::PIXEL_BITS-1:0]   pixel,
    output rlcc_pkg::lin_word_t               word
);

    rlcc_pkg::lin_word_t word_reg;
    rlcc_pkg::lin_word_t word_next;

    logic [rlcc_pkg::CHAN_BITS-1:0] r5;
    logic [rlcc_pkg::CHAN_BITS-1:0] g5;
    logic [rlcc_pkg::CHAN_BITS-1:0] b5;

    // channel fields
    assign r5 = pixel[rlcc_pkg::CHAN_BITS-1:0];
    assign g5 = pixel[2*rlcc_pkg::CHAN_BITS-1:rlcc_pkg::CHAN_BITS];
    assign b5 = pixel[3*rlcc_pkg::CHAN_BITS-1:2*rlcc_pkg::CHAN_BITS];

    // table lookups
    always_comb
    begin
        word_next.mode  = mode;
        word_next.pixel = pixel;
        word_next.lr    = rlcc_pkg::LIN_TABLE[r5];
        word_next.lg    = rlcc_pkg::LIN_TABLE[g5];
        word_next.lb    = rlcc_pkg::LIN_TABLE[b5];
    end

    // stage register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule

// ===== rtl/core/rlcc_mix.sv =====
// pipeline stage 2: weighted channel mixing with the fixed 3x3 matrix
// depends on rlcc_pkg (weights, lin_word_t, mix_word_t)
module rlcc_mix (
    input  logic                  clk,
    input  logic                  adv,
    input  rlcc_pkg::lin_word_t   word_in,
    output rlcc_pkg::mix_word_t   word
);

    rlcc_pkg::mix_word_t word_reg;
    rlcc_pkg::mix_word_t word_next;

    rlcc_pkg::mix_t lr;
    rlcc_pkg::mix_t lg;
    rlcc_pkg::mix_t lb;

    assign lr = rlcc_pkg::mix_t'(word_in.lr);
    assign lg = rlcc_pkg::mix_t'(word_in.lg);
    assign lb = rlcc_pkg::mix_t'(word_in.lb);

    // constant-weight sums, each below 2^25
    always_comb
    begin
        word_next.mode  = word_in.mode;
        word_next.pixel = word_in.pixel;
        word_next.sr    = rlcc_pkg::mix_t'(rlcc_pkg::W_RR) * lr
                        + rlcc_pkg::mix_t'(rlcc_pkg::W_RG) * lg
                        + rlcc_pkg::mix_t'(rlcc_pkg::W_RB) * lb;
        word_next.sg    = rlcc_pkg::mix_t'(rlcc_pkg::W_GR) * lr
                        + rlcc_pkg::mix_t'(rlcc_pkg::W_GG) * lg
                        + rlcc_pkg::mix_t'(rlcc_pkg::W_GB) * lb;
        word_next.sb    = rlcc_pkg::mix_t'(rlcc_pkg::W_BR) * lr
                        + rlcc_pkg::mix_t'(rlcc_pkg::W_BG) * lg
                        + rlcc_pkg::mix_t'(rlcc_pkg::W_BB) * lb;
    end

    // stage register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule

// ===== rtl/core/rlcc_div255.sv =====
// pipeline stage 3: divide each mixed sum by 255 via reciprocal multiply
// depends on rlcc_pkg (DIV_MUL, DIV_SHIFT, mix_word_t, sum_word_t)
module rlcc_div255 (
    input  logic                  clk,
    input  logic                  adv,
    input  rlcc_pkg::mix_word_t   word_in,
    output rlcc_pkg::sum_word_t   word
);

    rlcc_pkg::sum_word_t word_reg;
    rlcc_pkg::sum_word_t word_next;

    rlcc_pkg::prod_t prod_r;
    rlcc_pkg::prod_t prod_g;
    rlcc_pkg::prod_t prod_b;

    // one 25x26 multiply per lane
    assign prod_r = rlcc_pkg::prod_t'(word_in.sr) * rlcc_pkg::prod_t'(rlcc_pkg::DIV_MUL);
    assign prod_g = rlcc_pkg::prod_t'(word_in.sg) * rlcc_pkg::prod_t'(rlcc_pkg::DIV_MUL);
    assign prod_b = rlcc_pkg::prod_t'(word_in.sb) * rlcc_pkg::prod_t'(rlcc_pkg::DIV_MUL);

    // quotient is the top slice of the product
    always_comb
    begin
        word_next.mode  = word_in.mode;
        word_next.pixel = word_in.pixel;
        word_next.sr    = prod_r[rlcc_pkg::DIV_SHIFT +: rlcc_pkg::SUM_BITS];
        word_next.sg    = prod_g[rlcc_pkg::DIV_SHIFT +: rlcc_pkg::SUM_BITS];
        word_next.sb    = prod_b[rlcc_pkg::DIV_SHIFT +: rlcc_pkg::SUM_BITS];
    end

    // stage register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule

// ===== rtl/core/rlcc_out_gamma.sv =====
// pipeline stage 4: output gamma lookup or plain widening, into the output register
// depends on rlcc_pkg (GAMMA_TABLE, widen5, sum_word_t, rgb_word_t) and the macros header
`include "rgb555_lcd_color_correct_macros.svh"

module rlcc_out_gamma (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  word_valid,
    input  rlcc_pkg::sum_word_t   word_in,
    output rlcc_pkg::rgb_word_t   word
);

    rlcc_pkg::rgb_word_t word_reg;
    rlcc_pkg::rgb_word_t word_next;

    logic [rlcc_pkg::GAMMA_INDEX_BITS-1:0] idx_r;
    logic [rlcc_pkg::GAMMA_INDEX_BITS-1:0] idx_g;
    logic [rlcc_pkg::GAMMA_INDEX_BITS-1:0] idx_b;

    logic [rlcc_pkg::CHAN_BITS-1:0] r5;
    logic [rlcc_pkg::CHAN_BITS-1:0] g5;
    logic [rlcc_pkg::CHAN_BITS-1:0] b5;

    // table index is the top bits of each sum
    assign idx_r = word_in.sr[rlcc_pkg::SUM_BITS-1 -: rlcc_pkg::GAMMA_INDEX_BITS];
    assign idx_g = word_in.sg[rlcc_pkg::SUM_BITS-1 -: rlcc_pkg::GAMMA_INDEX_BITS];
    assign idx_b = word_in.sb[rlcc_pkg::SUM_BITS-1 -: rlcc_pkg::GAMMA_INDEX_BITS];

    assign r5 = word_in.pixel[rlcc_pkg::CHAN_BITS-1:0];
    assign g5 = word_in.pixel[2*rlcc_pkg::CHAN_BITS-1:rlcc_pkg::CHAN_BITS];
    assign b5 = word_in.pixel[3*rlcc_pkg::CHAN_BITS-1:2*rlcc_pkg::CHAN_BITS];

    // pick curve or replication per word
    always_comb
    begin
        word_next.mode = word_in.mode;
        if (word_in.mode)
        begin
            word_next.red   = rlcc_pkg::GAMMA_TABLE[idx_r];
            word_next.green = rlcc_pkg::GAMMA_TABLE[idx_g];
            word_next.blue  = rlcc_pkg::GAMMA_TABLE[idx_b];
        end
        else
        begin
            word_next.red   = rlcc_pkg::widen5(r5);
            word_next.green = rlcc_pkg::widen5(g5);
            word_next.blue  = rlcc_pkg::widen5(b5);
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

    // plain words must carry replicated red and blue channel bits
    `RLCC_ASSERT_NOW(a_plain_red_repl, word_valid && !word_reg.mode, (word_reg.red[15:11] == word_reg.red[10:6]) && (word_reg.red[0] == word_reg.red[15]), "plain red not replicated")
    `RLCC_ASSERT_NOW(a_plain_blue_repl, word_valid && !word_reg.mode, (word_reg.blue[15:11] == word_reg.blue[5:1]) && (word_reg.blue[0] == word_reg.blue[15]), "plain blue not replicated")

endmodule

// ===== rtl/core/rgb555_lcd_color_correct.sv =====
// top level of the lcd colour correction block: config register, valid chain, stages
// depends on rlcc_pkg, rlcc_pixel_if, rlcc_rgb_if, the four stage modules and the macros header
//
// Usage:
// - pixel_in carries one 15-bit pixel per word (red bits 0-4, green 5-9, blue 10-14);
//   a word is taken on a rising edge with valid and ready both high.
// - rgb_out returns 16-bit red, green and blue per word, in order, one per pixel.
// - color_emulation_we / color_emulation_wdata write the mode bit: 1 applies the
//   gamma 4 linearisation, channel mixing and gamma 1/2.2 output curve, 0 widens
//   each channel by bit replication. Write it only while the pipeline is empty.
// - An accepted word moves through the stage registers in order and is shown on
//   rgb_out from the output register.
// - Throughput: one pixel per cycle while the receiver is ready; four register stages
//   (table lookup, mixing sums, reciprocal multiply for the divide by 255, output
//   curve lookup), the last being the output register.
// - Reset empties every stage and clears the mode bit to plain replication.
// - When the receiver stalls, each stage holds its word and pixel_in.ready drops
//   only once all four stages are full; bubbles are squeezed out meanwhile.
`include "rgb555_lcd_color_correct_macros.svh"

module rgb555_lcd_color_correct (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           color_emulation_we,
    input  logic           color_emulation_wdata,
    rlcc_pixel_if.sink     pixel_in,
    rlcc_rgb_if.source     rgb_out
);

    logic color_emulation_reg;
    logic color_emulation_next;

    logic v1_reg;
    logic v1_next;
    logic v2_reg;
    logic v2_next;
    logic v3_reg;
    logic v3_next;
    logic v4_reg;
    logic v4_next;

    logic adv1;
    logic adv2;
    logic adv3;
    logic adv4;

    rlcc_pkg::lin_word_t lin_word;
    rlcc_pkg::mix_word_t mix_word;
    rlcc_pkg::sum_word_t sum_word;
    rlcc_pkg::rgb_word_t rgb_word;

    // mode register
    assign color_emulation_next = color_emulation_we ? color_emulation_wdata
                                                     : color_emulation_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_emulation_reg <= 1'b0;
        end
        else
        begin
            color_emulation_reg <= color_emulation_next;
        end
    end

    // stage advance: a stage loads when empty or when its successor moves
    assign adv4 = !v4_reg || rgb_out.ready;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign pixel_in.ready = adv1;

    // valid bits travel with the words
    assign v1_next = adv1 ? pixel_in.valid : v1_reg;
    assign v2_next = adv2 ? v1_reg : v2_reg;
    assign v3_next = adv3 ? v2_reg : v3_reg;
    assign v4_next = adv4 ? v3_reg : v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // datapath stages
    rlcc_linearise u_linearise (
        .clk   (clk),
        .adv   (adv1),
        .mode  (color_emulation_reg),
        .pixel (pixel_in.pixel_bgr555),
        .word  (lin_word)
    );

    rlcc_mix u_mix (
        .clk     (clk),
        .adv     (adv2),
        .word_in (lin_word),
        .word    (mix_word)
    );

    rlcc_div255 u_div255 (
        .clk     (clk),
        .adv     (adv3),
        .word_in (mix_word),
        .word    (sum_word)
    );

    rlcc_out_gamma u_out_gamma (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv4),
        .word_valid (v4_reg),
        .word_in    (sum_word),
        .word       (rgb_word)
    );

    // output channel
    assign rgb_out.valid     = v4_reg;
    assign rgb_out.red_out   = rgb_word.red;
    assign rgb_out.green_out = rgb_word.green;
    assign rgb_out.blue_out  = rgb_word.blue;

    // back-pressure only when every stage holds a word
    `RLCC_ASSERT_NOW(a_full_when_blocked, !pixel_in.ready,
        v1_reg && v2_reg && v3_reg && v4_reg && !rgb_out.ready,
        "input blocked with a free stage")
    // an accepted word lands in stage 1
    `RLCC_ASSERT_NEXT(a_accept_lands, pixel_in.valid && pixel_in.ready, v1_reg,
        "accepted word lost at stage 1")
    // a word moving out of stage 3 reaches the output register
    `RLCC_ASSERT_NEXT(a_stage3_moves, v3_reg && adv4, v4_reg,
        "word lost between stage 3 and output")

endmodule
